[sv/umbilical_door_latch_plant_top_defines.svh]
// Assertion macros used by the umbilical door latch plant RTL.
`ifndef UMBILICAL_DOOR_LATCH_PLANT_TOP_DEFINES_SVH
`define UMBILICAL_DOOR_LATCH_PLANT_TOP_DEFINES_SVH

// Same-cycle implication, checked on clk and quiet while rst_n is low.
`define UDL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and quiet while rst_n is low.
`define UDL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/udl_pkg.sv]
package udl_pkg;

  localparam int POS_BITS   = 20;
  localparam int TIME_BITS  = 8;
  localparam int RATE_W     = 16;
  localparam int DRIVE_W    = 3;
  localparam int ELAPSED_W  = 8;
  localparam int POS_OUT_W  = 20;
  localparam int PROD_W     = TIME_BITS + RATE_W;
  localparam int SUM_W      = ((PROD_W > POS_BITS) ? PROD_W : POS_BITS) + 4;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 96;

  typedef logic [POS_BITS-1:0]       pos_t;
  typedef logic [PROD_W-1:0]         prod_t;
  typedef logic signed [DRIVE_W-1:0] drive_t;
  typedef logic [RATE_W-1:0]         rate_t;
  typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;

  // Register indexes of the configuration port.
  localparam cfg_idx_t REG_DOOR_RATE       = 2'd0;
  localparam cfg_idx_t REG_DOOR_LATCH_RATE = 2'd1;
  localparam cfg_idx_t REG_CL_LATCH_RATE   = 2'd2;

  localparam rate_t DOOR_RATE_RST       = 16'd22;
  localparam rate_t DOOR_LATCH_RATE_RST = 16'd87;
  localparam rate_t CL_LATCH_RATE_RST   = 16'd87;

  localparam longint unsigned FULL_L = (64'd1 << POS_BITS) - 64'd1;
  localparam pos_t POS_FULL  = pos_t'(FULL_L);
  localparam pos_t POS_HALF  = pos_t'(64'd1 << (POS_BITS - 1));
  localparam pos_t POS_CAP   = pos_t'((FULL_L * 49 + 25) / 50);
  localparam pos_t POS_FLOOR = pos_t'((FULL_L + 25) / 50);
  localparam pos_t POS_RTL   = pos_t'((FULL_L + 50) / 100);
  localparam pos_t POS_ZERO  = '0;

  // Registered front half of one tick: the time-rate products, drives and latch switches.
  typedef struct packed {
    prod_t  door_prod;
    prod_t  latch_prod;
    prod_t  cl_prod;
    drive_t ldoor_drv;
    drive_t rdoor_drv;
    drive_t left_latch_drv;
    drive_t right_latch_drv;
    drive_t cl_one_drv;
    drive_t cl_two_drv;
    logic   left_sw;
    logic   right_sw;
  } tick_t;

  // pos + prod * drive, clamped to lo..hi.
  function automatic pos_t move_pos(pos_t pos, prod_t prod, drive_t drive,
                                    pos_t lo, pos_t hi);
    logic signed [SUM_W-1:0] prod_x;
    logic signed [SUM_W-1:0] drv_x;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] lo_x;
    logic signed [SUM_W-1:0] hi_x;
    pos_t                    res;
    prod_x = $signed({{(SUM_W-PROD_W){1'b0}}, prod});
    drv_x  = SUM_W'(drive);
    lo_x   = $signed({{(SUM_W-POS_BITS){1'b0}}, lo});
    hi_x   = $signed({{(SUM_W-POS_BITS){1'b0}}, hi});
    sum    = $signed({{(SUM_W-POS_BITS){1'b0}}, pos}) + prod_x * drv_x;
    if (sum < lo_x) begin
      res = lo;
    end else if (sum > hi_x) begin
      res = hi;
    end else begin
      res = sum[POS_BITS-1:0];
    end
    return res;
  endfunction

  // Door travel with the interlocks against the latches.
  function automatic pos_t door_step(pos_t pos, pos_t latch, prod_t prod,
                                     drive_t drive, logic cl_past, logic cl_below);
    pos_t lo;
    pos_t hi;
    pos_t res;
    lo = (latch < POS_HALF) ? POS_FLOOR : POS_ZERO;
    hi = cl_past ? POS_CAP : POS_FULL;
    if ((pos != POS_FULL || cl_below) && (pos != POS_ZERO || latch > POS_HALF)) begin
      res = move_pos(pos, prod, drive, lo, hi);
    end else begin
      res = pos;
    end
    return res;
  endfunction

  function automatic logic [1:0] end_status(pos_t pos);
    return {pos == POS_FULL, pos == POS_ZERO};
  endfunction

  function automatic logic [3:0] door_status(pos_t pos, logic other_sw);
    logic rtl;
    rtl = (pos <= POS_RTL);
    return {rtl, rtl | other_sw, end_status(pos)};
  endfunction

endpackage

[sv/umbilical_door_latch_plant_top.sv]
// Umbilical door latch plant: one input word is one simulation tick. The
// block moves the two door latches and the two centerline latches by
// elapsed_time x rate x drive, then moves the two doors under their latch
// interlocks, and returns one output word with limit-switch status and four
// positions (20-bit fractions, full scale is fully open). It takes one word
// per clock cycle without gaps while the output is not stalled. The first
// step registers an accepted word's elapsed-time by rate products, the
// second applies them to the six position registers and loads the output
// register. Only that second step reads and writes the mechanism state, so
// consecutive ticks chain at full rate. The user must write the rates
// through the cfg port while no tick is in flight; the block does not enforce it.
module umbilical_door_latch_plant_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [udl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [udl_pkg::RATE_W-1:0]      cfg_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // elapsed_time[7:0], ldoor_drive[10:8], rdoor_drive[13:11],
  // left_latch_drive[16:14], right_latch_drive[19:17],
  // centerline_one_drive[22:20], centerline_two_drive[25:23],
  // left_latch_switch[26], right_latch_switch[27], zero fill[31:28]
  input  logic [udl_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // ldoor_status[3:0], rdoor_status[7:4], left_latch_status[9:8],
  // right_latch_status[11:10], centerline_one_status[13:12],
  // centerline_two_status[15:14], ldoor_position[35:16],
  // rdoor_position[55:36], centerline_one_position[75:56],
  // centerline_two_position[95:76]
  output logic [udl_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import udl_pkg::*;

`include "umbilical_door_latch_plant_top_defines.svh"

  // Rate registers.
  rate_t door_rate_r, latch_rate_r, cl_rate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      door_rate_r  <= DOOR_RATE_RST;
      latch_rate_r <= DOOR_LATCH_RATE_RST;
      cl_rate_r    <= CL_LATCH_RATE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DOOR_RATE:       door_rate_r  <= cfg_data;
        REG_DOOR_LATCH_RATE: latch_rate_r <= cfg_data;
        REG_CL_LATCH_RATE:   cl_rate_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: the product stage advances whenever the output register is
  // free or is being emptied in this cycle.
  logic  tick_vld_r;
  tick_t tick_r, tick_nxt;
  logic  adv;
  logic  in_acc;

  assign adv       = tick_vld_r && (!out_tvalid || out_tready);
  assign in_tready = !tick_vld_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  logic [TIME_BITS-1:0] dt;
  assign dt = in_tdata[TIME_BITS-1:0];

  always_comb begin
    tick_nxt.door_prod       = prod_t'(dt) * prod_t'(door_rate_r);
    tick_nxt.latch_prod      = prod_t'(dt) * prod_t'(latch_rate_r);
    tick_nxt.cl_prod         = prod_t'(dt) * prod_t'(cl_rate_r);
    tick_nxt.ldoor_drv       = in_tdata[10:8];
    tick_nxt.rdoor_drv       = in_tdata[13:11];
    tick_nxt.left_latch_drv  = in_tdata[16:14];
    tick_nxt.right_latch_drv = in_tdata[19:17];
    tick_nxt.cl_one_drv      = in_tdata[22:20];
    tick_nxt.cl_two_drv      = in_tdata[25:23];
    tick_nxt.left_sw         = in_tdata[26];
    tick_nxt.right_sw        = in_tdata[27];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_vld_r <= 1'b0;
    end else if (in_tready) begin
      tick_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      tick_r <= tick_nxt;
    end
  end

  // Mechanism state. Latches move first; the doors then see the new latch
  // and centerline positions.
  pos_t ldoor_r, rdoor_r, llatch_r, rlatch_r, cl1_r, cl2_r;
  pos_t ldoor_nxt, rdoor_nxt, llatch_nxt, rlatch_nxt, cl1_nxt, cl2_nxt;
  logic cl_past, cl_below;

  always_comb begin
    llatch_nxt = move_pos(llatch_r, tick_r.latch_prod, tick_r.left_latch_drv,
                          POS_ZERO, POS_FULL);
    rlatch_nxt = move_pos(rlatch_r, tick_r.latch_prod, tick_r.right_latch_drv,
                          POS_ZERO, POS_FULL);
    cl1_nxt    = move_pos(cl1_r, tick_r.cl_prod, tick_r.cl_one_drv, POS_ZERO, POS_FULL);
    cl2_nxt    = move_pos(cl2_r, tick_r.cl_prod, tick_r.cl_two_drv, POS_ZERO, POS_FULL);
    cl_past    = (cl1_nxt > POS_HALF) || (cl2_nxt > POS_HALF);
    cl_below   = (cl1_nxt < POS_HALF) && (cl2_nxt < POS_HALF);
    ldoor_nxt  = door_step(ldoor_r, llatch_nxt, tick_r.door_prod, tick_r.ldoor_drv,
                           cl_past, cl_below);
    rdoor_nxt  = door_step(rdoor_r, rlatch_nxt, tick_r.door_prod, tick_r.rdoor_drv,
                           cl_past, cl_below);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ldoor_r  <= POS_ZERO;
      rdoor_r  <= POS_ZERO;
      llatch_r <= POS_ZERO;
      rlatch_r <= POS_ZERO;
      cl1_r    <= POS_ZERO;
      cl2_r    <= POS_ZERO;
    end else if (adv) begin
      ldoor_r  <= ldoor_nxt;
      rdoor_r  <= rdoor_nxt;
      llatch_r <= llatch_nxt;
      rlatch_r <= rlatch_nxt;
      cl1_r    <= cl1_nxt;
      cl2_r    <= cl2_nxt;
    end
  end

  // Output register. The left door reports the right latch switch and the
  // right door the left one.
  logic                  out_vld_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  always_comb begin
    out_data_nxt = {POS_OUT_W'(cl2_nxt), POS_OUT_W'(cl1_nxt),
                    POS_OUT_W'(rdoor_nxt), POS_OUT_W'(ldoor_nxt),
                    end_status(cl2_nxt), end_status(cl1_nxt),
                    end_status(rlatch_nxt), end_status(llatch_nxt),
                    door_status(rdoor_nxt, tick_r.left_sw),
                    door_status(ldoor_nxt, tick_r.right_sw)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  `UDL_ASSERT_NEXT(a_state_holds, !adv,
    $stable(ldoor_r) && $stable(cl1_r) && $stable(llatch_r),
    "mechanism state changed without a tick")
  `UDL_ASSERT_NEXT(a_out_matches_state, adv,
    out_tdata[35:16] == POS_OUT_W'(ldoor_r) && out_tdata[95:76] == POS_OUT_W'(cl2_r),
    "output word does not match updated state")
  `UDL_ASSERT_NOW(a_stall_means_full, !in_tready, tick_vld_r && out_tvalid,
    "input stalled while pipeline has room")
  `UDL_ASSERT_NOW(a_rtl_bits, out_tvalid && out_tdata[3], out_tdata[2],
    "ready line two without lines one and three")

endmodule

[dv/umbilical_door_latch_plant_top_test.sv]
`timescale 1ns / 100ps

module umbilical_door_latch_plant_top_test;
  import udl_pkg::*;

  // Pipeline allowance for the block. After the last expected word arrives,
  // drain_pipeline waits out slack based on it before the rate registers are touched.
  localparam int PIPE_LATENCY = 2;
  // Cycles with no word moving on either side before the run is declared hung.
  // The longest deliberate stall is the receiver hold of HOLD_CYCLES.
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int BLOCK_TICKS  = 100;
  localparam int MAX_REPORTS  = 10;

  // Index 3 is decoded by nothing, so a write to it must leave every rate alone.
  localparam cfg_idx_t REG_SPARE = 2'd3;

  // One input word, packed exactly as the in_tdata comment lays it out.
  typedef struct packed {
    logic [3:0] fill;
    logic       right_sw;
    logic       left_sw;
    drive_t     cl_two;
    drive_t     cl_one;
    drive_t     right_latch;
    drive_t     left_latch;
    drive_t     rdoor;
    drive_t     ldoor;
    logic [7:0] elapsed;
  } tick_word_t;

  // One output word, packed as the out_tdata comment lays it out.
  typedef struct packed {
    pos_t       cl_two_position;
    pos_t       cl_one_position;
    pos_t       rdoor_position;
    pos_t       ldoor_position;
    logic [1:0] cl_two_status;
    logic [1:0] cl_one_status;
    logic [1:0] right_latch_status;
    logic [1:0] left_latch_status;
    logic [3:0] rdoor_status;
    logic [3:0] ldoor_status;
  } plant_word_t;

  // Phases of a normal door operation. The random traffic mostly walks through
  // them in order, so the doors really open and close; the noise phase throws
  // arbitrary drive codes at every mechanism.
  typedef enum int {
    STG_RELEASE, STG_OPEN, STG_DEPLOY, STG_STOW, STG_CLOSE, STG_ENGAGE, STG_NOISE
  } stage_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  cfg_idx_t    cfg_index = '0;
  rate_t       cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;

  // Percent chances of an idle cycle on the sending side and of a stall on the
  // receiving side; hold_len forces a long receiver stall when set.
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_len = 0;

  int mismatch_count = 0;
  int quiet_cycles = 0;

  // Our own copy of the rate registers and of the six mechanism positions.
  rate_t door_rate_m  = DOOR_RATE_RST;
  rate_t latch_rate_m = DOOR_LATCH_RATE_RST;
  rate_t cl_rate_m    = CL_LATCH_RATE_RST;
  pos_t  ldoor_now        = '0;
  pos_t  rdoor_now        = '0;
  pos_t  left_latch_now   = '0;
  pos_t  right_latch_now  = '0;
  pos_t  cl_one_now       = '0;
  pos_t  cl_two_now       = '0;

  // Output words predicted for ticks already taken, oldest first.
  plant_word_t expected_words[$];

  umbilical_door_latch_plant_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Plant prediction
  // ---------------------------------------------------------------------------

  // Moves a position by dt x rate x drive and keeps the result inside lo..hi.
  // The sum is formed in 64 bits so that no overshoot can wrap.
  function automatic pos_t slide(pos_t pos, longint dt, rate_t rate, drive_t drv,
                                 pos_t lo, pos_t hi);
    longint target;
    target = longint'(pos) + dt * longint'(rate) * longint'(drv);
    if (target < longint'(lo)) return lo;
    if (target > longint'(hi)) return hi;
    return pos_t'(target);
  endfunction

  // A door is frozen when fully open while a centerline latch is not below
  // half, or when shut while its own latch is not past half. Otherwise it is
  // held below the cap while a centerline latch is out, and above the floor
  // while its own latch is still engaged; both limits apply even with no drive.
  function automatic pos_t swing_door(pos_t pos, pos_t latch, longint dt, drive_t drv);
    logic cl_out;
    logic cl_in;
    pos_t lo;
    pos_t hi;
    cl_out = (cl_one_now > POS_HALF) || (cl_two_now > POS_HALF);
    cl_in  = (cl_one_now < POS_HALF) && (cl_two_now < POS_HALF);
    if ((pos == POS_FULL && !cl_in) || (pos == POS_ZERO && !(latch > POS_HALF))) begin
      return pos;
    end
    hi = cl_out ? POS_CAP : POS_FULL;
    lo = (latch < POS_HALF) ? POS_FLOOR : POS_ZERO;
    return slide(pos, dt, door_rate_m, drv, lo, hi);
  endfunction

  function automatic logic [1:0] travel_ends(pos_t p);
    logic [1:0] flags;
    flags[0] = (p == POS_ZERO);
    flags[1] = (p == POS_FULL);
    return flags;
  endfunction

  // Ready-to-latch: a door close to shut raises both lines; otherwise line two
  // drops and lines one/three follow the latch switch of the other side.
  function automatic logic [3:0] door_switches(pos_t p, logic other_sw);
    logic [3:0] flags;
    flags[1:0] = travel_ends(p);
    flags[3]   = (p <= POS_RTL);
    flags[2]   = flags[3] || other_sw;
    return flags;
  endfunction

  // Advances the plant by one tick and returns the word the block should send.
  // Latches move first; the doors then see the latch positions of this tick.
  function automatic plant_word_t advance_plant(tick_word_t w);
    longint      dt;
    plant_word_t r;
    dt = longint'(w.elapsed);
    left_latch_now  = slide(left_latch_now, dt, latch_rate_m, w.left_latch,
                            POS_ZERO, POS_FULL);
    right_latch_now = slide(right_latch_now, dt, latch_rate_m, w.right_latch,
                            POS_ZERO, POS_FULL);
    cl_one_now      = slide(cl_one_now, dt, cl_rate_m, w.cl_one, POS_ZERO, POS_FULL);
    cl_two_now      = slide(cl_two_now, dt, cl_rate_m, w.cl_two, POS_ZERO, POS_FULL);
    ldoor_now       = swing_door(ldoor_now, left_latch_now, dt, w.ldoor);
    rdoor_now       = swing_door(rdoor_now, right_latch_now, dt, w.rdoor);
    r.ldoor_status        = door_switches(ldoor_now, w.right_sw);
    r.rdoor_status        = door_switches(rdoor_now, w.left_sw);
    r.left_latch_status   = travel_ends(left_latch_now);
    r.right_latch_status  = travel_ends(right_latch_now);
    r.cl_one_status       = travel_ends(cl_one_now);
    r.cl_two_status       = travel_ends(cl_two_now);
    r.ldoor_position      = ldoor_now;
    r.rdoor_position      = rdoor_now;
    r.cl_one_position     = cl_one_now;
    r.cl_two_position     = cl_two_now;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic tick_word_t tick_of(int el, int ld, int rd, int ll, int rl,
                                         int c1, int c2, bit lsw, bit rsw);
    tick_word_t w;
    w.fill        = '0;
    w.elapsed     = 8'(el);
    w.ldoor       = drive_t'(ld);
    w.rdoor       = drive_t'(rd);
    w.left_latch  = drive_t'(ll);
    w.right_latch = drive_t'(rl);
    w.cl_one      = drive_t'(c1);
    w.cl_two      = drive_t'(c2);
    w.left_sw     = lsw;
    w.right_sw    = rsw;
    return w;
  endfunction

  // Offers one tick word, with random idle cycles in front of it, and waits
  // until the block takes it. Valid is left high afterwards so that back to
  // back words go out without a bubble.
  task automatic send_tick(tick_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    do @(posedge clk); while (!in_tready);
    expected_words.push_back(advance_plant(w));
  endtask

  // Stops offering words and waits until every predicted word has come back,
  // plus a little slack for anything still inside the block.
  task automatic drain_pipeline();
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, rate_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_DOOR_RATE:       door_rate_m  = val;
      REG_DOOR_LATCH_RATE: latch_rate_m = val;
      REG_CL_LATCH_RATE:   cl_rate_m    = val;
      default: ;
    endcase
  endtask

  // Only called with the block drained.
  task automatic program_rates(rate_t door_r, rate_t latch_r, rate_t cl_r);
    cfg_write(REG_DOOR_RATE, door_r);
    cfg_write(REG_DOOR_LATCH_RATE, latch_r);
    cfg_write(REG_CL_LATCH_RATE, cl_r);
    cfg_we <= 1'b0;
  endtask

  // Rates span standstill, a crawl, moderate speeds and a full-scale slam.
  function automatic rate_t pick_rate();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return rate_t'($urandom_range(1, 100));
      3, 4:    return rate_t'($urandom_range(500, 5000));
      default: return rate_t'($urandom_range(16'hFFFF));
    endcase
  endfunction

  // Mostly short ticks so positions creep through their range, with some empty
  // and some full-length ticks.
  function automatic logic [7:0] pick_elapsed();
    case ($urandom_range(9))
      0:       return 8'd0;
      1, 2:    return 8'($urandom_range(255));
      3:       return 8'd255;
      default: return 8'($urandom_range(1, 24));
    endcase
  endfunction

  // A motor pair that the phase drives runs the given way at one or two units,
  // now and then with an arbitrary code; the others are mostly at rest.
  function automatic drive_t pick_drive(int dir);
    if (dir != 0) begin
      if ($urandom_range(9) == 0) return drive_t'($urandom_range(7));
      return drive_t'(dir * int'($urandom_range(1, 2)));
    end
    if ($urandom_range(99) < 15) return drive_t'($urandom_range(7));
    return drive_t'(0);
  endfunction

  task automatic run_stage(stage_t stg, int len);
    int         latch_dir;
    int         door_dir;
    int         cl_dir;
    tick_word_t w;
    latch_dir = (stg == STG_RELEASE) ? 1 : (stg == STG_ENGAGE) ? -1 : 0;
    door_dir  = (stg == STG_OPEN)    ? 1 : (stg == STG_CLOSE)  ? -1 : 0;
    cl_dir    = (stg == STG_DEPLOY)  ? 1 : (stg == STG_STOW)   ? -1 : 0;
    repeat (len) begin
      w.fill     = '0;
      w.elapsed  = pick_elapsed();
      w.left_sw  = 1'($urandom_range(1));
      w.right_sw = 1'($urandom_range(1));
      if (stg == STG_NOISE) begin
        w.ldoor       = drive_t'($urandom_range(7));
        w.rdoor       = drive_t'($urandom_range(7));
        w.left_latch  = drive_t'($urandom_range(7));
        w.right_latch = drive_t'($urandom_range(7));
        w.cl_one      = drive_t'($urandom_range(7));
        w.cl_two      = drive_t'($urandom_range(7));
      end else begin
        w.ldoor       = pick_drive(door_dir);
        w.rdoor       = pick_drive(door_dir);
        w.left_latch  = pick_drive(latch_dir);
        w.right_latch = pick_drive(latch_dir);
        w.cl_one      = pick_drive(cl_dir);
        w.cl_two      = pick_drive(cl_dir);
      end
      send_tick(w);
    end
  endtask

  // Sends a run of operation phases. Most of the time the next phase of a
  // normal release-open-deploy-stow-close-engage cycle follows; otherwise
  // any phase, noise included, is picked.
  task automatic run_operations(int ticks);
    int     sent;
    int     len;
    stage_t stg;
    sent = 0;
    stg  = stage_t'($urandom_range(STG_ENGAGE));
    while (sent < ticks) begin
      len = $urandom_range(3, 30);
      run_stage(stg, len);
      sent += len;
      if ($urandom_range(9) < 8) begin
        stg = (stg >= STG_ENGAGE) ? STG_RELEASE : stage_t'(int'(stg) + 1);
      end else begin
        stg = stage_t'($urandom_range(STG_NOISE));
      end
    end
  endtask

  // One traffic phase: several blocks of ticks, each under freshly written
  // rates. With extremes set, the first two blocks pin every rate to its
  // top and then its bottom value.
  task automatic run_traffic(int idle, int stall, int blocks, bit extremes);
    idle_pct  = idle;
    stall_pct = stall;
    for (int b = 0; b < blocks; b++) begin
      drain_pipeline();
      if (extremes && b == 0) begin
        program_rates(16'hFFFF, 16'hFFFF, 16'hFFFF);
      end else if (extremes && b == 1) begin
        program_rates('0, '0, '0);
      end else begin
        program_rates(pick_rate(), pick_rate(), pick_rate());
      end
      run_operations(BLOCK_TICKS);
    end
    drain_pipeline();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Directed ticks through every interlock. The first few run under the reset
  // rates and leave everything back at zero. Then with a latch rate of 2048,
  // 128 ms at drive 2 puts both door latches exactly on half, where a shut door
  // may not move. The left latch is nudged past half, the left door creeps to
  // about 0.01, and re-engaging its latch makes the door jump to the floor with
  // no drive. With a full-scale door rate the door then runs into the cap while
  // a centerline latch is out, opens fully once both are stowed, and sticks
  // fully open when a centerline latch deploys again.
  task automatic test_directed_interlocks();
    idle_pct  = 0;
    stall_pct = 0;
    send_tick(tick_of(255, -4, -4, -4, -4, -4, -4, 1, 1));
    send_tick(tick_of(0, 3, 3, 3, 3, 3, 3, 0, 0));
    send_tick(tick_of(1, 1, 1, 1, 1, 1, 1, 1, 0));
    send_tick(tick_of(255, -2, -2, -2, -2, -2, -2, 0, 1));
    drain_pipeline();
    cfg_write(REG_SPARE, 16'hFFFF);
    program_rates(16'd41, 16'd2048, 16'd2048);
    send_tick(tick_of(128, 2, 2, 2, 2, 0, 0, 1, 0));
    send_tick(tick_of(1, 1, 1, 1, 0, 0, 0, 0, 0));
    send_tick(tick_of(255, 1, 0, 0, 0, 0, 0, 0, 1));
    send_tick(tick_of(0, 0, 0, 0, 0, 0, 0, 1, 0));
    send_tick(tick_of(255, 0, 0, -4, 0, 0, 0, 0, 0));
    send_tick(tick_of(255, -4, 0, 3, 0, 3, 0, 1, 1));
    drain_pipeline();
    program_rates(16'hFFFF, 16'd2048, 16'd2048);
    send_tick(tick_of(255, 2, 0, 0, 0, 0, 0, 0, 0));
    send_tick(tick_of(255, 2, 0, 0, 0, -4, 0, 1, 1));
    send_tick(tick_of(255, -2, 0, 0, 0, 2, 0, 0, 1));
    send_tick(tick_of(10, -1, 0, 0, 0, -1, 1, 1, 0));
    send_tick(tick_of(255, -2, 0, 0, 0, -2, -2, 0, 0));
    send_tick(tick_of(255, 1, 3, 0, -2, 0, 0, 1, 1));
    drain_pipeline();
  endtask

  task automatic test_streaming_no_idle();
    run_traffic(0, 0, 4, 1'b1);
  endtask

  task automatic test_sender_gaps();
    run_traffic(70, 0, 4, 1'b0);
  endtask

  task automatic test_receiver_stalls();
    run_traffic(0, 70, 4, 1'b0);
  endtask

  task automatic test_mixed_idle();
    run_traffic(18, 18, 4, 1'b0);
  endtask

  // The receiver holds off for a long stretch while words keep coming, so the
  // block fills and has to push back on its input.
  task automatic test_full_stall();
    idle_pct  = 0;
    stall_pct = 0;
    drain_pipeline();
    program_rates(pick_rate(), pick_rate(), pick_rate());
    hold_len = HOLD_CYCLES;
    run_operations(60);
    drain_pipeline();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_interlocks();
    test_streaming_no_idle();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idle();
    test_full_stall();
    drain_pipeline();
    if (mismatch_count == 0) begin
      $display("umbilical_door_latch_plant_top_test passed");
    end else begin
      $display("umbilical_door_latch_plant_top_test failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver, checker and watchdog
  // ---------------------------------------------------------------------------

  // Random stalls at the current rate, or a forced hold while hold_len counts
  // down.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_tready <= 1'b0;
        hold_len = hold_len - 1;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic check_field(string name, logic [19:0] want, logic [19:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
      end
    end
  endtask

  // Every word the block hands over is compared with the oldest prediction.
  always @(posedge clk) begin
    plant_word_t got;
    plant_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("%0t: output word %h with no tick outstanding", $realtime, out_tdata);
        end
      end else begin
        want = expected_words.pop_front();
        check_field("ldoor_status", 20'(want.ldoor_status), 20'(got.ldoor_status));
        check_field("rdoor_status", 20'(want.rdoor_status), 20'(got.rdoor_status));
        check_field("left_latch_status", 20'(want.left_latch_status),
                    20'(got.left_latch_status));
        check_field("right_latch_status", 20'(want.right_latch_status),
                    20'(got.right_latch_status));
        check_field("centerline_one_status", 20'(want.cl_one_status),
                    20'(got.cl_one_status));
        check_field("centerline_two_status", 20'(want.cl_two_status),
                    20'(got.cl_two_status));
        check_field("ldoor_position", want.ldoor_position, got.ldoor_position);
        check_field("rdoor_position", want.rdoor_position, got.rdoor_position);
        check_field("centerline_one_position", want.cl_one_position,
                    got.cl_one_position);
        check_field("centerline_two_position", want.cl_two_position,
                    got.cl_two_position);
      end
    end
  end

  // Ends the run if no word moves on either side for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("umbilical_door_latch_plant_top_test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
